FILE: hw/rtl/scdec_pkg.sv
// Package for the signed integer to decimal text unit.
// Holds shared constants, the sequencer state type and the datapath control struct.
// No dependencies.
package scdec_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CHAR_W = 6;
	localparam int DIGIT_W = 4;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] ADJ_ADD = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic drain;
	} dd_ctrl_t;

endpackage

FILE: hw/rtl/scdec_dabble.sv
// Shift-and-add-three datapath: magnitude shift register and packed BCD register.
// One conversion step per cycle under control of the sequencer; drains digits MSB first.
// Depends on scdec_pkg.
module scdec_dabble #(
	parameter int VALUE_WIDTH = scdec_pkg::VALUE_WIDTH_DEF,
	parameter int NUM_DIGITS = 10
) (
	input  logic                                clk,
	input  scdec_pkg::dd_ctrl_t                 ctrl,
	input  logic [VALUE_WIDTH-1:0]              load_mag,
	output logic [scdec_pkg::DIGIT_W-1:0]       top_digit
);

	localparam int BCD_W = scdec_pkg::DIGIT_W * NUM_DIGITS;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;

	always_comb begin
		logic [scdec_pkg::DIGIT_W-1:0] dig;
		bcd_adj = bcd_q;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			dig = bcd_q[scdec_pkg::DIGIT_W*i +: scdec_pkg::DIGIT_W];
			if (dig >= scdec_pkg::ADJ_LIMIT) begin
				bcd_adj[scdec_pkg::DIGIT_W*i +: scdec_pkg::DIGIT_W] = dig + scdec_pkg::ADJ_ADD;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= load_mag;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (ctrl.drain) begin
			bcd_q <= {bcd_q[BCD_W-scdec_pkg::DIGIT_W-1:0], {scdec_pkg::DIGIT_W{1'b0}}};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: scdec_pkg::DIGIT_W];

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Signed integer to decimal ASCII text: top level with sequencer and output register.
// Sequence: on start the magnitude is loaded, then converted by one shift-and-add-three step per
// input bit; a minus sign is sent if the value was negative, then the digits follow MSB first,
// one digit per cycle, with leading zeros suppressed and the final digit always sent.
// A new value is taken only once the previous one is finished and busy is low.
// The receiver cannot stall; every strobed beat is taken. Reset returns the sequencer to idle.
module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = scdec_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [VALUE_WIDTH-1:0]     value,
	output logic                              strobe,
	output logic [scdec_pkg::CHAR_W-1:0]      character,
	output logic                              last
);

	localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int CW = $clog2(VALUE_WIDTH);

	scdec_pkg::state_t   state_q, state_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic                neg_q, neg_d;
	logic                started_q, started_d;
	scdec_pkg::dd_ctrl_t ctrl;
	logic [VALUE_WIDTH-1:0] load_mag;
	logic [scdec_pkg::DIGIT_W-1:0] top_digit;

	logic                        emit;
	logic [scdec_pkg::CHAR_W-1:0] char_d;
	logic                        last_d;

	logic                        strobe_q;
	logic [scdec_pkg::CHAR_W-1:0] character_q;
	logic                        last_q;

	assign load_mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	scdec_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NUM_DIGITS(NUM_DIGITS)
	) u_dabble (
		.clk(clk),
		.ctrl(ctrl),
		.load_mag(load_mag),
		.top_digit(top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scdec_pkg::ST_IDLE;
			cnt_q <= '0;
			neg_q <= 1'b0;
			started_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			neg_q <= neg_d;
			started_q <= started_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			character_q <= char_d;
			last_q <= last_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		neg_d = neg_q;
		started_d = started_q;
		ctrl = '0;
		emit = 1'b0;
		char_d = scdec_pkg::CHAR_ZERO;
		last_d = 1'b0;
		busy = 1'b1;
		case (state_q)
			scdec_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.load = 1'b1;
					neg_d = value[VALUE_WIDTH-1];
					started_d = 1'b0;
					cnt_d = CW'(VALUE_WIDTH - 1);
					state_d = scdec_pkg::ST_CONV;
				end
			end
			scdec_pkg::ST_CONV: begin
				ctrl.step = 1'b1;
				if (cnt_q == '0) begin
					cnt_d = CW'(NUM_DIGITS - 1);
					state_d = neg_q ? scdec_pkg::ST_SIGN : scdec_pkg::ST_DIGITS;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			scdec_pkg::ST_SIGN: begin
				emit = 1'b1;
				char_d = scdec_pkg::CHAR_MINUS;
				state_d = scdec_pkg::ST_DIGITS;
			end
			scdec_pkg::ST_DIGITS: begin
				ctrl.drain = 1'b1;
				emit = started_q || (top_digit != '0) || (cnt_q == '0);
				char_d = scdec_pkg::CHAR_ZERO + {2'b00, top_digit};
				last_d = (cnt_q == '0);
				started_d = started_q | emit;
				if (cnt_q == '0) begin
					state_d = scdec_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			default: begin
				state_d = scdec_pkg::ST_IDLE;
			end
		endcase
	end

	assign strobe = strobe_q;
	assign character = character_q;
	assign last = last_q;

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == scdec_pkg::CHAR_MINUS) ||
			((character >= scdec_pkg::CHAR_ZERO) &&
			(character <= scdec_pkg::CHAR_ZERO + {2'b00, scdec_pkg::DIGIT_MAX})))
		else $error("character outside the decimal text alphabet");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && character == scdec_pkg::CHAR_MINUS) |-> !last)
		else $error("minus sign marked as last beat");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("beat straight after the last beat of a number");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("unit not busy after accepting an item");

endmodule
